// ----- hdl/sha_pkg.sv -----
`default_nettype none
package sha_pkg;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_w0;
		logic [31:0] digest_w1;
		logic [31:0] digest_w2;
		logic [31:0] digest_w3;
		logic [31:0] digest_w4;
		logic [31:0] digest_w5;
		logic [31:0] digest_w6;
		logic [31:0] digest_w7;
	} out_item_t;

	// Block command handed from the front part to the compression engine.
	typedef struct packed {
		logic [511:0] block;
		logic         final_blk;
	} blk_cmd_t;

	localparam logic [255:0] H_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [6:0] LENGTH_POS = 7'd56;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction
endpackage
`default_nettype wire

// ----- hdl/sha_front.sv -----
`default_nettype none
// Packs bytes into 512-bit blocks and builds the padding blocks.
module sha_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sha_pkg::in_item_t  in_item,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output sha_pkg::blk_cmd_t       cmd,
	output logic                    cmd_valid,
	input  wire logic               cmd_ready
);
	typedef enum logic [2:0] {
		ST_BYTES = 3'b001,
		ST_PAD1  = 3'b010,
		ST_PAD2  = 3'b100
	} fr_state_t;

	fr_state_t     state_q;
	logic [511:0]  buf_q;
	logic [5:0]    fill_q;
	logic [63:0]   bits_q;
	logic          bytes_acc;
	logic [63:0]   bits_nx;
	logic [511:0]  buf_nx;
	logic [5:0]    pos;
	logic [511:0]  pad_blk;

	assign in_ready  = (state_q == ST_BYTES) && !cmd_valid;
	assign bytes_acc = in_valid && in_ready;
	assign pos       = fill_q;

	always_comb begin
		buf_nx  = buf_q;
		bits_nx = bits_q;
		if (in_item.has_byte) begin
			buf_nx[511 - 8*pos -: 8] = in_item.data_byte;
			bits_nx = bits_q + 64'd8;
		end
	end

	// Pad from fill_q onward; the final block ends in the 64-bit length.
	always_comb begin
		pad_blk = buf_q;
		for (int i = 0; i < 64; i++) begin
			if (i[6:0] == {1'b0, fill_q}) pad_blk[511 - 8*i -: 8] = sha_pkg::PAD_MARK;
			else if (i[6:0] > {1'b0, fill_q}) pad_blk[511 - 8*i -: 8] = 8'h00;
		end
		if ((state_q == ST_PAD1) && ({1'b0, fill_q} < sha_pkg::LENGTH_POS))
			pad_blk[63:0] = bits_q;
		if (state_q == ST_PAD2) begin
			pad_blk = '0;
			pad_blk[63:0] = bits_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_BYTES;
			fill_q    <= '0;
			bits_q    <= '0;
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) cmd_valid <= 1'b0;
			case (state_q)
				ST_BYTES: begin
					if (bytes_acc) begin
						buf_q  <= buf_nx;
						bits_q <= bits_nx;
						if (in_item.has_byte) fill_q <= fill_q + 6'd1;
						if (in_item.has_byte && fill_q == 6'd63) begin
							cmd.block     <= buf_nx;
							cmd.final_blk <= 1'b0;
							cmd_valid     <= 1'b1;
						end
						if (in_item.last) state_q <= ST_PAD1;
					end
				end
				ST_PAD1: begin
					if (!cmd_valid) begin
						cmd.block <= pad_blk;
						cmd_valid <= 1'b1;
						if ({1'b0, fill_q} < sha_pkg::LENGTH_POS) begin
							cmd.final_blk <= 1'b1;
							state_q <= ST_BYTES;
							fill_q  <= '0;
							bits_q  <= '0;
						end else begin
							cmd.final_blk <= 1'b0;
							state_q <= ST_PAD2;
						end
					end
				end
				ST_PAD2: begin
					if (!cmd_valid) begin
						cmd.block     <= pad_blk;
						cmd.final_blk <= 1'b1;
						cmd_valid     <= 1'b1;
						state_q       <= ST_BYTES;
						fill_q        <= '0;
						bits_q        <= '0;
					end
				end
				default: state_q <= ST_BYTES;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/sha_core.sv -----
`default_nettype none
// Iterative compression, one round per cycle, with a digest output register.
module sha_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sha_pkg::blk_cmd_t  cmd,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	output sha_pkg::out_item_t      out_item,
	output logic                    out_valid,
	input  wire logic               out_ready
);
	logic [255:0]  h_q;
	logic [31:0]   v_q [8];
	logic [31:0]   w_q [16];
	logic [5:0]    rnd_q;
	logic          busy_q;
	logic          fin_q;
	logic          done_q;
	logic [31:0]   t1, t2, s0, s1, wn, e, a;
	logic [255:0]  h_sum;

	assign cmd_ready = !busy_q && !done_q && !(out_valid && !out_ready);
	assign e = v_q[4];
	assign a = v_q[0];

	always_comb begin
		t1 = v_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
		   + ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::round_k(rnd_q) + w_q[0];
		t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
		   + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
		s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
		   ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
		for (int i = 0; i < 8; i++)
			h_sum[255 - 32*i -: 32] = h_q[255 - 32*i -: 32] + v_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q       <= sha_pkg::H_INIT;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			out_valid <= 1'b0;
			rnd_q     <= '0;
			fin_q     <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd_valid && cmd_ready) begin
				busy_q <= 1'b1;
				fin_q  <= cmd.final_blk;
				rnd_q  <= '0;
				for (int i = 0; i < 16; i++) w_q[i] <= cmd.block[511 - 32*i -: 32];
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[255 - 32*i -: 32];
			end else if (busy_q) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= wn;
				v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= e;
				v_q[4] <= v_q[3] + t1; v_q[3] <= v_q[2]; v_q[2] <= v_q[1];
				v_q[1] <= a; v_q[0] <= t1 + t2;
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q) begin
				done_q <= 1'b0;
				if (fin_q) begin
					out_item  <= h_sum;
					out_valid <= 1'b1;
					h_q       <= sha_pkg::H_INIT;
				end else begin
					h_q <= h_sum;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/sha256_stream_hash_unit.sv -----
`default_nettype none
// SHA-256 engine for a byte stream.
// The input channel (in_item, in_valid, in_ready) takes at most one item per
// cycle: an optional message byte and a flag marking the end of the message.
// An item with last set yields exactly one result item on the output channel
// (out_item, out_valid, out_ready): the 256-bit digest as eight words.
// The front part collects bytes into a 512-bit block and builds the padding;
// a one-entry block register lets it keep taking bytes while the back part
// runs the compression. The back part runs one round a cycle. Input stalls
// after each full block, until the back part takes it, and from a last item
// until its padding blocks are handed on.
// Reset loads the initial hash values and clears all counters and valid flags.
// A stalled receiver holds the digest in the output register; the engine
// stops before taking the next block, and input backs up behind it.
module sha256_stream_hash_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sha_pkg::in_item_t  in_item,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output sha_pkg::out_item_t      out_item,
	output logic                    out_valid,
	input  wire logic               out_ready
);
	sha_pkg::blk_cmd_t cmd;
	logic              cmd_valid;
	logic              cmd_ready;

	sha_front u_front (
		.clk, .arst_n, .in_item, .in_valid, .in_ready,
		.cmd, .cmd_valid, .cmd_ready
	);

	sha_core u_core (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_ready,
		.out_item, .out_valid, .out_ready
	);
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
module tb;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES = 300;

	// Scoreboard: a software SHA-256 that follows the stream item by item and
	// queues each digest that a last item produces.
	class digest_scoreboard;
		logic [31:0] chain [8];
		logic [7:0]  blk [64];
		int          fill;
		logic [63:0] msg_bits;
		sha_pkg::out_item_t digests_due [$];
		int          mismatches;
		int          digests_seen;

		function new();
			mismatches = 0;
			digests_seen = 0;
			restart();
		endfunction

		function void restart();
			logic [255:0] h;
			h = sha_pkg::H_INIT;
			for (int i = 0; i < 8; i++) chain[i] = h[255 - 32 * i -: 32];
			fill = 0;
			msg_bits = '0;
		endfunction

		function logic [31:0] rotr(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [64];
			logic [31:0] v [8];
			logic [31:0] t1, t2, e, a;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (int i = 16; i < 64; i++)
				w[i] = w[i-16] + w[i-7]
					+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
					+ (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
			for (int i = 0; i < 8; i++) v[i] = chain[i];
			for (int i = 0; i < 64; i++) begin
				e = v[4];
				a = v[0];
				t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
					+ ((e & v[5]) ^ (~e & v[6])) + sha_pkg::round_k(i[5:0]) + w[i];
				t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
					+ ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) chain[i] += v[i];
		endfunction

		// Notes one accepted input item.
		function void note_item(sha_pkg::in_item_t it);
			sha_pkg::out_item_t d;
			if (it.has_byte) begin
				blk[fill] = it.data_byte;
				fill++;
				msg_bits += 64'd8;
				if (fill == 64) begin
					compress();
					fill = 0;
				end
			end
			if (!it.last) return;
			blk[fill] = sha_pkg::PAD_MARK;
			fill++;
			if (fill > int'(sha_pkg::LENGTH_POS)) begin
				while (fill < 64) begin
					blk[fill] = 8'h00;
					fill++;
				end
				compress();
				fill = 0;
			end
			while (fill < int'(sha_pkg::LENGTH_POS)) begin
				blk[fill] = 8'h00;
				fill++;
			end
			for (int i = 0; i < 8; i++) blk[63 - i] = msg_bits[8*i +: 8];
			compress();
			d = {chain[0], chain[1], chain[2], chain[3],
				chain[4], chain[5], chain[6], chain[7]};
			digests_due.push_back(d);
			restart();
		endfunction

		// Checks one accepted digest against the oldest one due.
		function void check_digest(sha_pkg::out_item_t got);
			sha_pkg::out_item_t want;
			digests_seen++;
			if (digests_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected digest %h", got);
				return;
			end
			want = digests_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("digest mismatch: expected %h got %h", want, got);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	sha_pkg::in_item_t   in_item = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	sha_pkg::out_item_t  out_item;
	logic       out_valid;
	logic       out_ready = 1'b0;

	digest_scoreboard sb = new();
	bit  hold_off = 1'b0;
	int  idle_cycles = 0;
	int  items_sent = 0;
	int  messages_sent = 0;

	always #1 clk = ~clk;

	sha256_stream_hash_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_item(out_item),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	// Both channels are sampled at the rising edge; the scoreboard sees every
	// accepted item in the order the block took it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_item(in_item);
			if (out_valid && out_ready) sb.check_digest(out_item);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// The watchdog ends a run in which nothing moves for a long time.
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", idle_cycles);
			$display("tb: FAIL");
			$finish;
		end
	end

	// Sender bursts: a random run of items, then a random gap that is often empty.
	int burst_left = 0;

	// Offers one item at the falling edge and holds it until it is accepted.
	task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 0)
				@(negedge clk);
			burst_left = $urandom_range(1, 120);
		end
		burst_left--;
		in_item <= '{data_byte: b, has_byte: hb, last: lst};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
		if (lst) messages_sent++;
	endtask

	// Sends a message of len bytes; the final byte may ride on the last item,
	// and stray items with neither byte nor last are mixed in now and then.
	task automatic send_message(input int len, input bit byte_on_last, input int noise);
		for (int i = 0; i < len; i++) begin
			if (noise > 0 && $urandom_range(0, 99) < noise)
				send_item(8'($urandom), 1'b0, 1'b0);
			if (i == len - 1 && byte_on_last)
				send_item(8'($urandom), 1'b1, 1'b1);
			else
				send_item(8'($urandom), 1'b1, 1'b0);
		end
		if (len == 0 || !byte_on_last)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Receiver stalls on its own pattern; hold_off forces a long stall.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
			end else begin
				case ($urandom_range(0, 3))
					0: out_ready <= 1'b0;
					default: out_ready <= 1'b1;
				endcase
			end
		end
	end

	// One long stretch with the receiver held off, counted in its own process;
	// the sender keeps offering items, and input backs up behind the held digest.
	initial begin
		@(posedge arst_n);
		wait (messages_sent >= 12);
		hold_off = 1'b1;
		repeat (3000) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		int len;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty message, padding boundaries around 55, 56 and
		// 64 bytes, extreme byte values, a byte on the last item, and an item
		// that carries nothing at all.
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'ha5, 1'b1, 1'b0);
		send_item(8'h3c, 1'b0, 1'b1);
		send_message(55, 1'b1, 0);
		send_message(56, 1'b0, 0);
		send_message(64, 1'b1, 0);

		// Random part: mostly short messages, a few long ones crossing blocks.
		while (items_sent < 900) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(100, 200);
				1, 2: len = $urandom_range(50, 70);
				default: len = $urandom_range(0, 20);
			endcase
			send_message(len, 1'($urandom), $urandom_range(0, 1) ? 10 : 0);
		end
		in_valid <= 1'b0;

		wait (sb.digests_due.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d items in %0d messages, %0d digests checked",
			items_sent, messages_sent, sb.digests_seen);
		if (sb.mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
